/* rtl/core/cqs_pkg.sv */
// ----------------------------------------------------------------------------
// cqs_pkg: circular queue with search, shared definitions
// Request and status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package cqs_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned DataW    = 32;

  typedef enum logic [1:0] {
    REQ_ENQ    = 2'd0,
    REQ_DEQ    = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_DUMP   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_ENQ      = 3'd0,
    ST_OVF      = 3'd1,
    ST_DEQ      = 3'd2,
    ST_UNF      = 3'd3,
    ST_FOUND    = 3'd4,
    ST_NOTFOUND = 3'd5,
    ST_DUMP     = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_POP,
    S_RESULT
  } seq_state_e;

  typedef logic signed [DataW-1:0] data_t;

endpackage

/* rtl/core/cqs_if.sv */
// ----------------------------------------------------------------------------
// cqs_req_if / cqs_rsp_if: request and response channels
// Valid/ready channels carrying one request word or one response word.
// ----------------------------------------------------------------------------
interface cqs_req_if;
  logic           valid;
  logic           ready;
  cqs_pkg::req_e  req_type;
  cqs_pkg::data_t value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface cqs_rsp_if;
  logic              valid;
  logic              ready;
  cqs_pkg::status_e  status;
  cqs_pkg::data_t    data;
  logic              dump_empty;
  logic              last;

  modport source (output valid, output status, output data, output dump_empty,
                  output last, input ready);
  modport sink   (input valid, input status, input data, input dump_empty,
                  input last, output ready);
endinterface

/* rtl/core/circular_queue_with_search.sv */
// ----------------------------------------------------------------------------
// circular_queue_with_search: ring FIFO with search and dump
// Enqueue, dequeue, search and dump requests on a ring of CAPACITY words.
//
//   channel | dir | word                                 | words per request
//   req_i   | in  | req_type, value                      | 1
//   rsp_o   | out | status, data, dump_empty, last       | 1, or count on nonempty dump
//
// Enqueue, overflow, underflow and empty dump answer from the execute state,
// dequeue from the pop state, search after its walk, dump during its walk.
// The single storage read port paces the walk at one entry a cycle, a dump
// only while the output is not stalled. The request side is ready only
// between requests. A stalled output holds the sequencer; the last word may
// wait while the next request enters. No storage clearing after reset.
// ----------------------------------------------------------------------------
module circular_queue_with_search #(
  parameter int unsigned CAPACITY = cqs_pkg::Capacity
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cqs_req_if.sink   req_i,
  cqs_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned SumW = IdxW + 2;

  function automatic logic [IdxW-1:0] wrap_add(logic [IdxW-1:0] base,
                                               logic [CntW-1:0] amount);
    logic [SumW-1:0] sum;
    sum = SumW'(base) + SumW'(amount);
    if (sum >= SumW'(CAPACITY)) begin
      sum = sum - SumW'(CAPACITY);
    end
    return sum[IdxW-1:0];
  endfunction

  function automatic logic [IdxW-1:0] wrap_next(logic [IdxW-1:0] idx);
    return (idx == IdxW'(CAPACITY - 1)) ? '0 : idx + IdxW'(1);
  endfunction

  cqs_pkg::seq_state_e state_q, state_d;
  cqs_pkg::req_e       req_q, req_d;
  cqs_pkg::data_t      val_q, val_d;
  logic [CntW-1:0]     off_q, off_d;
  logic                rd_vld_q, rd_vld_d;
  logic                hit_q, hit_d;
  logic [IdxW-1:0]     head_q, head_d;
  logic [IdxW-1:0]     tail_q, tail_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  logic                rsp_valid_q;
  cqs_pkg::status_e    status_q;
  cqs_pkg::data_t      data_q;
  logic                empty_q;
  logic                last_q;

  logic                out_free;
  logic                emit;
  cqs_pkg::status_e    emit_status;
  cqs_pkg::data_t      emit_data;
  logic                emit_empty;
  logic                emit_last;
  logic                wr_en;
  logic                rd_en;
  logic [IdxW-1:0]     rd_addr;
  cqs_pkg::data_t      rd_data;
  logic                consume;
  logic                full;

  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign full     = (cnt_q == CntW'(CAPACITY));
  assign rd_addr  = wrap_add(head_q, off_q);

  cqs_ring #(
    .Depth (CAPACITY),
    .AddrW (IdxW)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (tail_q),
    .wr_data_i (val_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cqs_pkg::S_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      cnt_q    <= '0;
      off_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      off_q    <= off_d;
      rd_vld_q <= rd_vld_d;
      hit_q    <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    val_q <= val_d;
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    val_d       = val_q;
    off_d       = off_q;
    rd_vld_d    = rd_vld_q;
    hit_d       = hit_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    emit        = 1'b0;
    emit_status = cqs_pkg::ST_ENQ;
    emit_data   = '0;
    emit_empty  = 1'b0;
    emit_last   = 1'b1;
    consume     = 1'b0;
    req_i.ready = 1'b0;

    unique case (state_q)
      cqs_pkg::S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          req_d    = req_i.req_type;
          val_d    = req_i.value;
          off_d    = '0;
          rd_vld_d = 1'b0;
          hit_d    = 1'b0;
          state_d  = cqs_pkg::S_EXEC;
        end
      end

      cqs_pkg::S_EXEC: begin
        unique case (req_q)
          cqs_pkg::REQ_ENQ: begin
            if (out_free) begin
              emit    = 1'b1;
              state_d = cqs_pkg::S_IDLE;
              if (full) begin
                emit_status = cqs_pkg::ST_OVF;
              end else begin
                wr_en       = 1'b1;
                tail_d      = wrap_next(tail_q);
                cnt_d       = cnt_q + CntW'(1);
                emit_status = cqs_pkg::ST_ENQ;
                emit_data   = val_q;
              end
            end
          end
          cqs_pkg::REQ_DEQ: begin
            if (cnt_q == '0) begin
              if (out_free) begin
                emit        = 1'b1;
                emit_status = cqs_pkg::ST_UNF;
                state_d     = cqs_pkg::S_IDLE;
              end
            end else begin
              rd_en   = 1'b1;
              state_d = cqs_pkg::S_POP;
            end
          end
          cqs_pkg::REQ_SEARCH: begin
            state_d = cqs_pkg::S_WALK;
          end
          cqs_pkg::REQ_DUMP: begin
            if (cnt_q == '0) begin
              if (out_free) begin
                emit        = 1'b1;
                emit_status = cqs_pkg::ST_DUMP;
                emit_empty  = 1'b1;
                state_d     = cqs_pkg::S_IDLE;
              end
            end else begin
              state_d = cqs_pkg::S_WALK;
            end
          end
          default: state_d = cqs_pkg::S_IDLE;
        endcase
      end

      cqs_pkg::S_WALK: begin
        consume = rd_vld_q && ((req_q == cqs_pkg::REQ_SEARCH) || out_free);
        if (consume) begin
          if (req_q == cqs_pkg::REQ_SEARCH) begin
            hit_d = hit_q || (rd_data == val_q);
          end else begin
            emit        = 1'b1;
            emit_status = cqs_pkg::ST_DUMP;
            emit_data   = rd_data;
            emit_last   = (off_q == cnt_q);
          end
        end
        if ((off_q != cnt_q) && (!rd_vld_q || consume)) begin
          rd_en    = 1'b1;
          off_d    = off_q + CntW'(1);
          rd_vld_d = 1'b1;
        end else if (consume) begin
          rd_vld_d = 1'b0;
        end
        if ((off_q == cnt_q) && (!rd_vld_q || consume)) begin
          state_d = (req_q == cqs_pkg::REQ_DUMP) ? cqs_pkg::S_IDLE : cqs_pkg::S_RESULT;
        end
      end

      cqs_pkg::S_POP: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = cqs_pkg::ST_DEQ;
          emit_data   = rd_data;
          head_d      = wrap_next(head_q);
          cnt_d       = cnt_q - CntW'(1);
          state_d     = cqs_pkg::S_IDLE;
        end
      end

      cqs_pkg::S_RESULT: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = hit_q ? cqs_pkg::ST_FOUND : cqs_pkg::ST_NOTFOUND;
          emit_data   = val_q;
          state_d     = cqs_pkg::S_IDLE;
        end
      end

      default: state_d = cqs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (emit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q <= emit_status;
      data_q   <= emit_data;
      empty_q  <= emit_empty;
      last_q   <= emit_last;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.data       = data_q;
  assign rsp_o.dump_empty = empty_q;
  assign rsp_o.last       = last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_ptr_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q == wrap_add(head_q, cnt_q))
    else $error("tail does not follow head plus count");

  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && empty_q) |-> (last_q && (status_q == cqs_pkg::ST_DUMP)))
    else $error("empty dump word malformed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while busy");

endmodule

/* rtl/core/cqs_ring.sv */
// ----------------------------------------------------------------------------
// cqs_ring: ring storage
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module cqs_ring #(
  parameter int unsigned Depth = cqs_pkg::Capacity,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  cqs_pkg::data_t   wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output cqs_pkg::data_t   rd_data_o
);

  cqs_pkg::data_t mem_q [Depth];
  cqs_pkg::data_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* sim/circular_queue_with_search_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_with_search_checker: response predictor and comparator
// Watches both channels, keeps its own ring of queued values, works out the
// response words owed for each accepted request and compares every accepted
// response word, field by field, with the oldest owed word.
// ----------------------------------------------------------------------------
module circular_queue_with_search_checker #(
  parameter int unsigned CAPACITY = cqs_pkg::Capacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cqs_req_if          req_i,
  cqs_rsp_if          rsp_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned words_owed_o
);
  import cqs_pkg::*;

  localparam int unsigned ReportMax = 10;

  typedef struct packed {
    status_e status;
    data_t   data;
    logic    dump_empty;
    logic    last;
  } rsp_word_t;

  data_t       ring_vals [CAPACITY];
  int unsigned ring_head;
  int unsigned ring_tail;
  int unsigned ring_fill;
  rsp_word_t   owed_words [$];

  task automatic owe_word(input status_e st, input data_t d, input logic empty,
                          input logic fin);
    rsp_word_t w;
    w.status     = st;
    w.data       = d;
    w.dump_empty = empty;
    w.last       = fin;
    owed_words.push_back(w);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    rsp_word_t   want;
    logic        hit;
    logic        bad;
    int unsigned slot;
    if (!rst_ni) begin
      ring_head      = 0;
      ring_tail      = 0;
      ring_fill      = 0;
      mismatch_cnt_o = 0;
      owed_words.delete();
    end else begin
      // compare the word leaving the block
      if (rsp_i.valid && rsp_i.ready) begin
        if (owed_words.size() == 0) begin
          mismatch_cnt_o++;
          if (mismatch_cnt_o <= ReportMax) begin
            $display("%0t: unexpected response word: status %0d data %0d dump_empty %b last %b",
                     $realtime, rsp_i.status, rsp_i.data, rsp_i.dump_empty, rsp_i.last);
          end
        end else begin
          want = owed_words.pop_front();
          bad  = 1'b0;
          if (rsp_i.status !== want.status) bad = 1'b1;
          if (rsp_i.data !== want.data) bad = 1'b1;
          if (rsp_i.dump_empty !== want.dump_empty) bad = 1'b1;
          if (rsp_i.last !== want.last) bad = 1'b1;
          if (bad) begin
            mismatch_cnt_o++;
            if (mismatch_cnt_o <= ReportMax) begin
              $display("%0t: response mismatch: expected status %0d data %0d dump_empty %b last %b",
                       $realtime, want.status, want.data, want.dump_empty, want.last);
              $display("%0t:                    actual   status %0d data %0d dump_empty %b last %b",
                       $realtime, rsp_i.status, rsp_i.data, rsp_i.dump_empty, rsp_i.last);
            end
          end
        end
      end
      // predict the words owed for the word entering the block
      if (req_i.valid && req_i.ready) begin
        case (req_i.req_type)
          REQ_ENQ: begin
            if (ring_fill == CAPACITY) begin
              owe_word(ST_OVF, '0, 1'b0, 1'b1);
            end else begin
              ring_vals[ring_tail] = req_i.value;
              ring_tail = (ring_tail + 1 == CAPACITY) ? 0 : ring_tail + 1;
              ring_fill++;
              owe_word(ST_ENQ, req_i.value, 1'b0, 1'b1);
            end
          end
          REQ_DEQ: begin
            if (ring_fill == 0) begin
              owe_word(ST_UNF, '0, 1'b0, 1'b1);
            end else begin
              owe_word(ST_DEQ, ring_vals[ring_head], 1'b0, 1'b1);
              ring_head = (ring_head + 1 == CAPACITY) ? 0 : ring_head + 1;
              ring_fill--;
            end
          end
          REQ_SEARCH: begin
            hit = 1'b0;
            for (int unsigned i = 0; i < ring_fill; i++) begin
              slot = (ring_head + i) % CAPACITY;
              if (ring_vals[slot] == req_i.value) hit = 1'b1;
            end
            owe_word(hit ? ST_FOUND : ST_NOTFOUND, req_i.value, 1'b0, 1'b1);
          end
          default: begin
            if (ring_fill == 0) begin
              owe_word(ST_DUMP, '0, 1'b1, 1'b1);
            end else begin
              for (int unsigned i = 0; i < ring_fill; i++) begin
                slot = (ring_head + i) % CAPACITY;
                owe_word(ST_DUMP, ring_vals[slot], 1'b0, (i + 1 == ring_fill));
              end
            end
          end
        endcase
      end
    end
    words_owed_o = owed_words.size();
  end

endmodule

/* sim/circular_queue_with_search_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_with_search_test: testbench top
// Drives request words into the queue through directed cases (empty and full
// queue, extreme values, every request kind) and then random phases with
// varying sender and receiver idling, including a long receiver hold-off.
// A checker beside the block predicts and compares the response words.
// ----------------------------------------------------------------------------
module circular_queue_with_search_test;
  import cqs_pkg::*;

  localparam int unsigned StallLimit    = 4000;
  localparam int unsigned HoldCycles    = 150;
  localparam int unsigned TailCycles    = 40;
  localparam int unsigned ItemsPerPhase = 22;
  localparam data_t       MinVal        = {1'b1, {(DataW - 1){1'b0}}};
  localparam data_t       MaxVal        = {1'b0, {(DataW - 1){1'b1}}};

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatch_cnt;
  int unsigned words_owed;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_req_cnt;
  data_t       recent_vals [8];
  int unsigned recent_wr;

  cqs_req_if req_ch ();
  cqs_rsp_if rsp_ch ();

  circular_queue_with_search dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  circular_queue_with_search_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_ch),
    .rsp_i          (rsp_ch),
    .mismatch_cnt_o (mismatch_cnt),
    .words_owed_o   (words_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : receiver
    int unsigned holds_done;
    holds_done = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req_cnt != holds_done) begin
        holds_done++;
        rsp_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("circular_queue_with_search_test: done, errors");
    $finish;
  end

  task automatic send_word(input req_e kind, input data_t val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.value    <= val;
    do @(posedge clk_i); while (!req_ch.ready);
    if (kind == REQ_ENQ) begin
      recent_vals[recent_wr] = val;
      recent_wr = (recent_wr + 1) % 8;
    end
  endtask

  task automatic wait_all_answered();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (words_owed == 0);
  endtask

  task automatic random_items(input int unsigned n, input int unsigned fill_pct);
    req_e        kind;
    data_t       val;
    int unsigned roll;
    int unsigned enq_pct;
    for (int unsigned i = 0; i < n; i++) begin
      enq_pct = ((i / 20) % 2 == 0) ? fill_pct : 25;
      roll = $urandom_range(99);
      if (roll < enq_pct) begin
        kind = REQ_ENQ;
      end else if (roll < enq_pct + (100 - enq_pct) / 2) begin
        kind = REQ_DEQ;
      end else if ($urandom_range(3) == 0) begin
        kind = REQ_DUMP;
      end else begin
        kind = REQ_SEARCH;
      end
      case ($urandom_range(4))
        0, 1:    val = recent_vals[$urandom_range(7)];
        2:       val = $urandom_range(1) ? MinVal : MaxVal;
        3:       val = data_t'($urandom_range(15));
        default: val = data_t'($urandom());
      endcase
      send_word(kind, val);
    end
  endtask

  initial begin : stimulus
    rst_ni          <= 1'b0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_ENQ;
    req_ch.value    <= '0;
    send_idle_pct    = 9;
    recv_idle_pct    = 66;
    hold_req_cnt     = 0;
    recent_wr        = 0;
    foreach (recent_vals[k]) recent_vals[k] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue
    send_word(REQ_DEQ, data_t'($urandom()));
    send_word(REQ_SEARCH, '0);
    send_word(REQ_DUMP, data_t'($urandom()));
    // extremes
    send_word(REQ_ENQ, MinVal);
    send_word(REQ_ENQ, MaxVal);
    send_word(REQ_ENQ, '0);
    send_word(REQ_ENQ, '1);
    send_word(REQ_SEARCH, MaxVal);
    send_word(REQ_SEARCH, data_t'(1));
    send_word(REQ_DUMP, '0);
    send_word(REQ_DEQ, '0);
    // fill to capacity, then overflow
    for (int k = 0; k < Capacity - 3; k++) send_word(REQ_ENQ, data_t'($urandom()));
    send_word(REQ_ENQ, MaxVal);
    send_word(REQ_SEARCH, MinVal);
    send_word(REQ_DUMP, '0);
    wait_all_answered();

    random_items(ItemsPerPhase, 70);
    wait_all_answered();

    // hold the receiver while requests keep coming
    hold_req_cnt++;
    for (int k = 0; k < 10; k++) send_word(REQ_ENQ, data_t'($urandom()));
    send_word(REQ_DUMP, '0);
    send_word(REQ_SEARCH, recent_vals[$urandom_range(7)]);
    wait_all_answered();

    send_idle_pct = 66;
    recv_idle_pct = 9;
    random_items(ItemsPerPhase, 60);
    wait_all_answered();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_items(ItemsPerPhase, 70);
    wait_all_answered();

    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && words_owed == 0) begin
      $display("circular_queue_with_search_test: done, clean");
    end else begin
      $display("circular_queue_with_search_test: done, errors");
    end
    $finish;
  end

endmodule
